// ===== src/dwmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwmd_pkg: shared types and constants
// Widths, defaults and the control struct for the distinct-window detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

  localparam int unsigned SYM_W          = 8;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned POS_W          = 20;
  localparam int unsigned MAX_WINDOW_DEF = 14;
  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam logic [CFG_W-1:0] WINDOW_RST = 4'd4;

  // control shared by every cell of the row
  typedef struct packed {
    logic adv;  // a word is taken this cycle: shift the row
    logic clr;  // that word ends the stream: drop the run
  } chain_ctrl_t;

endpackage
`default_nettype wire

// ===== src/dwmd_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwmd_cell: one history slot
// Holds one past symbol and a bit telling whether the slot lies inside the
// current run of distinct symbols. Hands its symbol to the next slot.
// ----------------------------------------------------------------------------
module dwmd_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  wire dwmd_pkg::chain_ctrl_t  ctrl,
  input  wire  [dwmd_pkg::SYM_W-1:0]  sym,       // incoming symbol, broadcast
  input  wire  [dwmd_pkg::SYM_W-1:0]  hist_in,   // symbol from previous slot
  input  wire                         run_in,    // new run bit for this slot
  output logic [dwmd_pkg::SYM_W-1:0]  hist_out,
  output logic                        run_out    // new run bit for next slot
);
  import dwmd_pkg::*;

  logic run;

  // next slot stays in the run only if this one was and holds no copy
  assign run_out = run_in & run & (hist_out != sym);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (ctrl.adv) begin
      run <= ctrl.clr ? 1'b0 : run_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      hist_out <= hist_in;
    end
  end

endmodule
`default_nettype wire

// ===== src/dwmd_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dwmd_chain: row of history cells
// Newest symbol enters cell 0; the run bits ripple down the row and give,
// for each depth, whether the newest symbols up to it are all distinct.
// ----------------------------------------------------------------------------
module dwmd_chain #(
  parameter int unsigned MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire dwmd_pkg::chain_ctrl_t ctrl,
  input  wire  [dwmd_pkg::SYM_W-1:0] sym,
  output logic [MAX_WINDOW-1:0]      distinct   // bit k: newest k+1 differ
);
  import dwmd_pkg::*;

  logic [SYM_W-1:0] hist [MAX_WINDOW+1];
  logic [MAX_WINDOW:0] run_chain;

  assign hist[0]      = sym;
  assign run_chain[0] = 1'b1;   // newest symbol alone is always distinct
  assign distinct     = run_chain[MAX_WINDOW-1:0];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    dwmd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sym      (sym),
      .hist_in  (hist[k]),
      .run_in   (run_chain[k]),
      .hist_out (hist[k+1]),
      .run_out  (run_chain[k+1])
    );
  end

endmodule
`default_nettype wire

// ===== src/distinct_window_marker_detect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_window_marker_detect: start-of-marker search on a byte stream
// Reports the first point where the newest window_size symbols all differ.
// ----------------------------------------------------------------------------
// Takes one symbol per cycle on the slave side unless a result is held
// (tlast marks the end of a stream) and gives at most one word per stream
// on the master side: tuser=1 with the symbol count up to and including the
// marker's last symbol, or, if the stream ends with no marker, tuser=0 and a
// zero count. Each word passes through a row of MAX_WINDOW history cells,
// where each cell compares its byte with the new symbol and a run bit ripples
// down the row. The result sits in an output register, and a new symbol is
// taken in the cycle the pending result is taken. The user writes window_size
// (1..MAX_WINDOW; 0 acts as 1, larger values clip) through cfg_wen/cfg_wdata
// while the block is idle; the block does not enforce this. After reset it
// is 4. The symbol count saturates at 2^COUNT_BITS-1 and the reported
// position at 2^20-1. All stream state clears after the word with tlast.
// ----------------------------------------------------------------------------
module distinct_window_marker_detect #(
  parameter int unsigned MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEF,
  parameter int unsigned COUNT_BITS = dwmd_pkg::COUNT_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  // configuration: window_size
  input  wire                         cfg_wen,
  input  wire  [dwmd_pkg::CFG_W-1:0]  cfg_wdata,
  // input stream
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [7:0]                  s_tdata,   // [7:0] symbol
  input  wire                         s_tlast,   // last_symbol
  // result stream
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [23:0]                 m_tdata,   // [19:0] position, [23:20] zero
  output logic                        m_tuser    // found
);
  import dwmd_pkg::*;

  localparam int unsigned IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned EW   = ($clog2(MAX_WINDOW + 1) > CFG_W) ?
                                 $clog2(MAX_WINDOW + 1) : CFG_W;
  localparam int unsigned CMPW = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;
  localparam logic [CMPW-1:0] POS_MAX = CMPW'((64'd1 << POS_W) - 64'd1);

  logic [CFG_W-1:0]      window_size;
  logic [COUNT_BITS-1:0] symbol_count;
  logic [COUNT_BITS-1:0] symbol_count_next;
  logic                  marker_done;
  logic [POS_W-1:0]      position;

  chain_ctrl_t           ctrl;
  logic                  s_acc;
  logic [MAX_WINDOW-1:0] distinct;
  logic [EW-1:0]         w_ext;
  logic [EW-1:0]         w_eff;
  logic [IW-1:0]         w_sel;
  logic                  hit;
  logic [CMPW-1:0]       cnt_ext;
  logic [POS_W-1:0]      pos_next;

  // output register frees up in the cycle its word is taken
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign ctrl.adv = s_acc;
  assign ctrl.clr = s_tlast;

  dwmd_chain #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sym      (s_tdata[SYM_W-1:0]),
    .distinct (distinct)
  );

  // clamp window to 1..MAX_WINDOW
  always_comb begin
    w_ext = EW'(window_size);
    if (window_size == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WINDOW)) begin
      w_eff = EW'(MAX_WINDOW);
    end else begin
      w_eff = w_ext;
    end
    w_sel = IW'(w_eff - EW'(1));
  end

  // run bits already exclude slots not yet filled in this stream
  assign hit = distinct[w_sel];

  always_comb begin
    if (symbol_count == '1) begin
      symbol_count_next = symbol_count;
    end else begin
      symbol_count_next = symbol_count + COUNT_BITS'(1);
    end
    cnt_ext  = CMPW'(symbol_count_next);
    pos_next = (cnt_ext > POS_MAX) ? POS_MAX[POS_W-1:0] : cnt_ext[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RST;
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      marker_done  <= 1'b0;
    end else if (s_acc) begin
      if (s_tlast) begin
        symbol_count <= '0;
        marker_done  <= 1'b0;
      end else begin
        symbol_count <= symbol_count_next;
        marker_done  <= marker_done || hit;
      end
    end
  end

  // result word: marker once per stream, or "none" at end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc && !marker_done && (hit || s_tlast)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && !marker_done && (hit || s_tlast)) begin
      m_tuser  <= hit;
      position <= hit ? pos_next : '0;
    end
  end

  assign m_tdata = {4'b0000, position};

  // a "none" word never carries a position
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (position == '0))
    else $error("no-marker word with nonzero position");

  // end of stream leaves no marker flag or count behind
  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast) |=> (!marker_done && symbol_count == '0))
    else $error("stream state not cleared after last symbol");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a pending result");

  // within a stream the count never goes down
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !s_tlast) |=> (symbol_count >= $past(symbol_count)))
    else $error("symbol count decreased mid-stream");

  // a marker word follows an accepted symbol while no marker was yet found
  a_marker_src: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) ##1 (m_tvalid && m_tuser) |->
      ($past(s_acc) && !$past(marker_done) && marker_done == !$past(s_tlast)))
    else $error("marker word without a matching symbol");

endmodule
`default_nettype wire
